[design/orl_pkg.sv]
package orl_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int ID_W        = 16;
    localparam int MARKS_W     = 10;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int LIST_N      = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_SEARCH = 3'd1,
        OP_DELETE = 3'd2,
        OP_LIST   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [MARKS_W-1:0] marks;
    } t_rec;

    // rot: every cell takes its neighbor; ins: the cell at 'at' takes the new
    // record; del: cells at or above 'at' take their neighbor
    typedef struct packed {
        logic             rot;
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] at;
    } t_cell_ctl;

endpackage

[design/orl_cell.sv]
module orl_cell (
    input  logic                      i_clk,
    input  orl_pkg::t_cell_ctl        i_ctl,
    input  logic [orl_pkg::IDX_W-1:0] i_idx,
    input  orl_pkg::t_rec             i_next,
    input  orl_pkg::t_rec             i_new,
    output orl_pkg::t_rec             o_rec
);
    import orl_pkg::*;

    t_rec r_rec;
    t_rec n_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.ins && (i_idx == i_ctl.at)) begin
            n_rec = i_new;
        end else if (i_ctl.rot) begin
            n_rec = i_next;
        end else if (i_ctl.del && (i_idx >= i_ctl.at)) begin
            // close the gap left by the deleted record
            n_rec = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

[design/ordered_record_list_core.sv]
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_stall | i_op, i_key_id, i_mark_value
// out     | output    | o_out_valid / i_out_stall | o_status, o_rec_id, o_rec_marks, o_last
//
// Insert, clear and every op on an empty list: result registered next cycle.
// Search and delete: the ring rotates every cell past the head cell in S_SCAN, then
// S_FINISH reports (and compacts the chain on delete).
// List: a full rotation of the ring, one record leaving the head each cycle; an
// output stall freezes the ring while a record waits to be emitted.
// Reset clears the state, the record count and the output valid; cell contents are undefined until written.
// The input stalls while a search, delete or list is running or the output holds.
module ordered_record_list_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [orl_pkg::OP_W-1:0]     i_op,
    input  logic [orl_pkg::ID_W-1:0]     i_key_id,
    input  logic [orl_pkg::MARKS_W-1:0]  i_mark_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [orl_pkg::STATUS_W-1:0] o_status,
    output logic [orl_pkg::ID_W-1:0]     o_rec_id,
    output logic [orl_pkg::MARKS_W-1:0]  o_rec_marks,
    output logic                         o_last
);
    import orl_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_step, n_step;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic              r_found, n_found;
    t_op               r_op, n_op;
    logic [ID_W-1:0]   r_key, n_key;
    t_rec              r_hit, n_hit;

    logic              r_out_valid, n_out_valid;
    t_status           r_status;
    t_rec              r_out_rec;
    logic              r_last;

    logic              w_ld;
    t_status           w_ld_status;
    t_rec              w_ld_rec;
    logic              w_ld_last;

    t_cell_ctl         w_ctl;
    t_rec              w_rec  [DEPTH];
    t_rec              w_next [DEPTH];
    t_rec              w_new;
    t_rec              w_head;

    logic              w_out_busy;
    logic              w_acc;
    logic              w_start;
    logic              w_step_end;
    logic [CNT_W-1:0]  w_t;
    logic [CNT_W-1:0]  w_nlist;
    logic              w_emit;
    logic              w_advance;
    t_op               w_in_op;

    assign w_new      = '{id: i_key_id, marks: i_mark_value};
    assign w_head     = w_rec[0];
    assign w_out_busy = r_out_valid && i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || w_out_busy;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_in_op    = t_op'(i_op);
    assign w_step_end = (r_step == IDX_W'(DEPTH - 1));
    assign w_t        = CNT_W'(r_step);
    assign w_nlist    = (r_count > CNT_W'(LIST_N)) ? CNT_W'(LIST_N) : r_count;
    assign w_emit     = (w_t < w_nlist);
    assign w_advance  = !(w_emit && w_out_busy);

    always_comb begin
        w_start = 1'b0;
        if (w_acc && (r_count != '0)) begin
            w_start = (w_in_op == OP_SEARCH) || (w_in_op == OP_DELETE) ||
                      (w_in_op == OP_LIST);
        end
    end

    // chain of cells, closed into a ring for rotation
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_next[g] = w_rec[(g + 1) % DEPTH];

        orl_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_idx  (IDX_W'(g)),
            .i_next (w_next[g]),
            .i_new  (w_new),
            .o_rec  (w_rec[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_step_end) begin
                    if (r_op == OP_LIST) begin
                        if (w_advance) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!w_out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_step      = r_step;
        n_pos       = r_pos;
        n_found     = r_found;
        n_op        = r_op;
        n_key       = r_key;
        n_hit       = r_hit;
        w_ctl       = '0;
        w_ld        = 1'b0;
        w_ld_status = ST_DONE;
        w_ld_rec    = '0;
        w_ld_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_step  = '0;
                    n_found = 1'b0;
                    n_op    = w_in_op;
                    n_key   = i_key_id;
                    unique case (w_in_op)
                        OP_INSERT: begin
                            w_ld = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                w_ld_status = ST_FULL;
                            end else begin
                                w_ctl.ins = 1'b1;
                                w_ctl.at  = r_count[IDX_W-1:0];
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_SEARCH, OP_DELETE: begin
                            if (r_count == '0) begin
                                w_ld        = 1'b1;
                                w_ld_status = ST_NOT_FOUND;
                            end
                        end
                        OP_LIST: begin
                            if (r_count == '0) begin
                                w_ld        = 1'b1;
                                w_ld_status = ST_EMPTY;
                            end
                        end
                        OP_CLEAR: begin
                            w_ld = 1'b1;
                            if (r_count == '0) begin
                                w_ld_status = ST_EMPTY;
                            end else begin
                                n_count = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_op == OP_LIST) begin
                    if (w_advance) begin
                        w_ctl.rot = 1'b1;
                        n_step    = r_step + 1'b1;
                        if (w_emit) begin
                            w_ld        = 1'b1;
                            w_ld_status = ST_FOUND;
                            w_ld_rec    = w_head;
                            w_ld_last   = ((w_t + 1'b1) == w_nlist);
                        end
                    end
                end else begin
                    w_ctl.rot = 1'b1;
                    n_step    = r_step + 1'b1;
                    // latch the first match as it passes the head
                    if ((w_t < r_count) && !r_found && (w_head.id == r_key)) begin
                        n_found = 1'b1;
                        n_pos   = r_step;
                        n_hit   = w_head;
                    end
                end
            end
            S_FINISH: begin
                if (!w_out_busy) begin
                    w_ld = 1'b1;
                    if (!r_found) begin
                        w_ld_status = ST_NOT_FOUND;
                    end else if (r_op == OP_DELETE) begin
                        w_ld_status = ST_DONE;
                        w_ctl.del   = 1'b1;
                        w_ctl.at    = r_pos;
                        n_count     = r_count - 1'b1;
                    end else begin
                        w_ld_status = ST_FOUND;
                        w_ld_rec    = r_hit;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = w_ld || w_out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_op    <= n_op;
        r_key   <= n_key;
        r_hit   <= n_hit;
        if (w_ld) begin
            r_status  <= w_ld_status;
            r_out_rec <= w_ld_rec;
            r_last    <= w_ld_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_rec_id    = r_out_rec.id;
    assign o_rec_marks = r_out_rec.marks;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("record count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_in_op == OP_INSERT) && (r_count != CNT_W'(DEPTH)))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not add a record");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && !w_out_busy && r_found && (r_op == OP_DELETE))
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("delete did not remove a record");

    a_no_load_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_busy |-> !w_ld)
        else $error("result loaded over a stalled transfer");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import orl_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;
    localparam int RANDOM_OPS  = 180;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 32;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    id;
        logic [MARKS_W-1:0] marks;
        logic               last;
    } t_reply;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    key;
        logic [MARKS_W-1:0] mark;
        logic [4:0]         reps;
        logic               typed;
        t_reply             want;
    } t_step_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_op = '0;
    logic [ID_W-1:0]     i_key_id = '0;
    logic [MARKS_W-1:0]  i_mark_value = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_rec_id;
    logic [MARKS_W-1:0]  o_rec_marks;
    logic                o_last;

    // shadow copy of the record list
    logic [ID_W-1:0]     list_ids [DEPTH];
    logic [MARKS_W-1:0]  list_marks [DEPTH];
    int                  list_len = 0;

    t_reply              replies_due [$];
    t_step_row           step_rows [$];
    t_reply              out_want;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    bit                  steady = 1'b0;

    ordered_record_list_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_key_id     (i_key_id),
        .i_mark_value (i_mark_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_rec_id     (o_rec_id),
        .o_rec_marks  (o_rec_marks),
        .o_last       (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_reply mk_reply(input t_status status, input logic [ID_W-1:0] id,
                                        input logic [MARKS_W-1:0] marks, input logic last);
        t_reply r;
        r.status = status;
        r.id     = id;
        r.marks  = marks;
        r.last   = last;
        return r;
    endfunction

    // Apply one operation to the shadow list and queue the replies it causes.
    task automatic predict_list_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] key,
                                   input logic [MARKS_W-1:0] mark);
        int hit;
        int n;
        hit = -1;
        for (int i = 0; i < list_len; i++)
            if (hit < 0 && list_ids[i] == key)
                hit = i;
        case (op)
            OP_INSERT: begin
                if (list_len >= DEPTH) begin
                    replies_due.push_back(mk_reply(ST_FULL, '0, '0, 1'b1));
                end else begin
                    list_ids[list_len]   = key;
                    list_marks[list_len] = mark;
                    list_len++;
                    replies_due.push_back(mk_reply(ST_DONE, '0, '0, 1'b1));
                end
            end
            OP_SEARCH: begin
                if (hit < 0)
                    replies_due.push_back(mk_reply(ST_NOT_FOUND, '0, '0, 1'b1));
                else
                    replies_due.push_back(mk_reply(ST_FOUND, list_ids[hit], list_marks[hit],
                                                   1'b1));
            end
            OP_DELETE: begin
                if (hit < 0) begin
                    replies_due.push_back(mk_reply(ST_NOT_FOUND, '0, '0, 1'b1));
                end else begin
                    // close the gap, keep the order of the rest
                    for (int i = hit; i + 1 < list_len; i++) begin
                        list_ids[i]   = list_ids[i + 1];
                        list_marks[i] = list_marks[i + 1];
                    end
                    list_len--;
                    replies_due.push_back(mk_reply(ST_DONE, '0, '0, 1'b1));
                end
            end
            OP_LIST: begin
                if (list_len == 0) begin
                    replies_due.push_back(mk_reply(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    n = (list_len < MAX_RESULTS) ? list_len : MAX_RESULTS;
                    for (int i = 0; i < n; i++)
                        replies_due.push_back(mk_reply(ST_FOUND, list_ids[i], list_marks[i],
                                                       i == n - 1));
                end
            end
            OP_CLEAR: begin
                if (list_len == 0) begin
                    replies_due.push_back(mk_reply(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    list_len = 0;
                    replies_due.push_back(mk_reply(ST_DONE, '0, '0, 1'b1));
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [ID_W-1:0] key,
                           input logic [MARKS_W-1:0] mark, input int reps, input bit typed,
                           input t_status status, input logic [ID_W-1:0] id,
                           input logic [MARKS_W-1:0] marks);
        t_step_row row;
        row.op    = op;
        row.key   = key;
        row.mark  = mark;
        row.reps  = reps[4:0];
        row.typed = typed;
        row.want  = mk_reply(status, id, marks, 1'b1);
        step_rows.push_back(row);
    endtask

    // Drive one transfer, hold it until accepted, then predict its replies.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] key,
                           input logic [MARKS_W-1:0] mark, input bit typed, input t_reply want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_key_id     <= key;
        i_mark_value <= mark;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_list_op(op, key, mark);
        if (typed) begin
            void'(replies_due.pop_back());
            replies_due.push_back(want);
        end
    endtask

    function automatic logic [ID_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55 && list_len > 0)
            return list_ids[$urandom_range(list_len - 1)];
        if (r < 80)
            return ID_W'(16'h00A0 + $urandom_range(7));
        if (r < 85)
            return $urandom_range(1) ? {ID_W{1'b1}} : '0;
        return ID_W'($urandom);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $error("unexpected transfer: status %0d id %0h marks %0h last %0b",
                       o_status, o_rec_id, o_rec_marks, o_last);
                mismatch_count++;
            end else begin
                out_want = replies_due.pop_front();
                if (o_status !== out_want.status) begin
                    $error("status: expected %0d, got %0d", out_want.status, o_status);
                    mismatch_count++;
                end
                if (o_rec_id !== out_want.id) begin
                    $error("rec_id: expected %0h, got %0h", out_want.id, o_rec_id);
                    mismatch_count++;
                end
                if (o_rec_marks !== out_want.marks) begin
                    $error("rec_marks: expected %0h, got %0h", out_want.marks, o_rec_marks);
                    mismatch_count++;
                end
                if (o_last !== out_want.last) begin
                    $error("last: expected %0b, got %0b", out_want.last, o_last);
                    mismatch_count++;
                end
            end
        end
        i_out_stall <= i_rst_n && !steady && ($urandom_range(99) < IDLE_PCT);
    end

    initial begin : stimulus
        t_step_row          row;
        int                 sent;
        int                 r;
        logic [OP_W-1:0]    op;

        // empty-list cases first
        add_row(OP_LIST,   16'h0000, 10'h000, 1, 1, ST_EMPTY,     '0,       '0);
        add_row(OP_CLEAR,  16'h0000, 10'h000, 1, 1, ST_EMPTY,     '0,       '0);
        add_row(OP_SEARCH, 16'h0000, 10'h3FF, 1, 1, ST_NOT_FOUND, '0,       '0);
        add_row(OP_DELETE, 16'hFFFF, 10'h000, 1, 1, ST_NOT_FOUND, '0,       '0);
        add_row(OP_INSERT, 16'h0000, 10'h000, 1, 1, ST_DONE,      '0,       '0);
        add_row(OP_INSERT, 16'hFFFF, 10'h3FF, 1, 1, ST_DONE,      '0,       '0);
        add_row(OP_RESERVED_FIRST, 16'hFFFF, 10'h3FF, 1, 0, ST_DONE, '0,    '0);
        add_row(OP_RESERVED_LAST,  16'h5A5A, 10'h2AA, 1, 0, ST_DONE, '0,    '0);
        add_row(OP_SEARCH, 16'hFFFF, 10'h000, 1, 1, ST_FOUND,     16'hFFFF, 10'h3FF);
        // fill to capacity, then overflow
        add_row(OP_INSERT, 16'h8000, 10'h155, DEPTH - 2, 1, ST_DONE, '0,    '0);
        add_row(OP_INSERT, 16'h1234, 10'h0AA, 1, 1, ST_FULL,      '0,       '0);
        add_row(OP_LIST,   16'h0000, 10'h000, 1, 0, ST_DONE,      '0,       '0);
        // delete head and a middle record
        add_row(OP_DELETE, 16'h0000, 10'h000, 1, 1, ST_DONE,      '0,       '0);
        add_row(OP_DELETE, 16'h8003, 10'h000, 1, 1, ST_DONE,      '0,       '0);
        add_row(OP_SEARCH, 16'h8004, 10'h000, 1, 1, ST_FOUND,     16'h8004, 10'h159);
        add_row(OP_LIST,   16'h0000, 10'h000, 1, 0, ST_DONE,      '0,       '0);
        add_row(OP_CLEAR,  16'h0000, 10'h000, 1, 1, ST_DONE,      '0,       '0);
        // delete the only record
        add_row(OP_INSERT, 16'hABCD, 10'h2AA, 1, 1, ST_DONE,      '0,       '0);
        add_row(OP_DELETE, 16'hABCD, 10'h000, 1, 1, ST_DONE,      '0,       '0);
        add_row(OP_LIST,   16'h0000, 10'h000, 1, 1, ST_EMPTY,     '0,       '0);
        add_row(OP_SEARCH, 16'hABCD, 10'h000, 1, 1, ST_NOT_FOUND, '0,       '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (step_rows[n]) begin
            row = step_rows[n];
            for (int k = 0; k < row.reps; k++)
                send_op(row.op, row.key + ID_W'(k), row.mark + MARKS_W'(k), row.typed,
                        row.want);
        end

        sent = 0;
        while (sent < RANDOM_OPS) begin
            steady = (sent >= 90 && sent < 150);
            r = $urandom_range(99);
            if (r < 45)
                op = OP_INSERT;
            else if (r < 60)
                op = OP_SEARCH;
            else if (r < 75)
                op = OP_DELETE;
            else if (r < 88)
                op = OP_LIST;
            else if (r < 91)
                // mostly clear a well-filled list so it still reaches capacity
                op = (list_len >= 8 || $urandom_range(3) == 0) ? OP_CLEAR : OP_SEARCH;
            else
                op = OP_W'(OP_RESERVED_FIRST + $urandom_range(2));
            send_op(op, pick_key(), MARKS_W'($urandom_range(1023)), 1'b0, '0);
            if (op <= OP_CLEAR)
                sent++;
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/orl_pkg.sv
design/orl_cell.sv
design/ordered_record_list_core.sv
tb/sv/testbench.sv
